[design/cpbf_pkg.sv]
// constants, state type and tag struct shared by the closest pair search block
`timescale 1ns / 1ps

package cpbf_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int COORD_WIDTH = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int DIST_W      = 2 * COORD_WIDTH + 1;
  localparam int OUT_DIST_W  = 33;
  localparam int INDEX_W     = 10;
  localparam int PAIR_W      = 19;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE_I,
    S_ISSUE_J,
    S_DRAIN,
    S_DONE
  } cpbf_state_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } cpbf_tag_t;

endpackage

[design/cpbf_dist.sv]
// pipelined squared distance unit shared by every pair of the search
`timescale 1ns / 1ps

module cpbf_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpbf_pkg::cpbf_tag_t                 in_tag,
  input  logic [cpbf_pkg::COORD_WIDTH-1:0]    ax,
  input  logic [cpbf_pkg::COORD_WIDTH-1:0]    ay,
  input  logic [cpbf_pkg::COORD_WIDTH-1:0]    bx,
  input  logic [cpbf_pkg::COORD_WIDTH-1:0]    by,
  output cpbf_pkg::cpbf_tag_t                 out_tag,
  output logic [cpbf_pkg::DIST_W-1:0]         sq_dist,
  output logic                                busy
);
  import cpbf_pkg::*;

  logic signed [COORD_WIDTH:0] dx, dy;
  logic [COORD_WIDTH:0]        adx, ady;
  logic [COORD_WIDTH-1:0]      abs_x_r, abs_y_r;
  logic [SQ_W-1:0]             sq_x_r, sq_y_r;
  logic [DIST_W-1:0]           dist_r;
  cpbf_tag_t                   tag1_r, tag2_r, tag3_r;

  assign dx  = $signed({ax[COORD_WIDTH-1], ax}) - $signed({bx[COORD_WIDTH-1], bx});
  assign dy  = $signed({ay[COORD_WIDTH-1], ay}) - $signed({by[COORD_WIDTH-1], by});
  assign adx = dx[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-dx) : dx;
  assign ady = dy[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-dy) : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      tag3_r.valid <= 1'b0;
    end else begin
      tag1_r.valid <= in_tag.valid;
      tag2_r.valid <= tag1_r.valid;
      tag3_r.valid <= tag2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r.i <= in_tag.i;
    tag1_r.j <= in_tag.j;
    tag2_r.i <= tag1_r.i;
    tag2_r.j <= tag1_r.j;
    tag3_r.i <= tag2_r.i;
    tag3_r.j <= tag2_r.j;
    abs_x_r  <= adx[COORD_WIDTH-1:0];
    abs_y_r  <= ady[COORD_WIDTH-1:0];
    sq_x_r   <= abs_x_r * abs_x_r;
    sq_y_r   <= abs_y_r * abs_y_r;
    dist_r   <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
  end

  assign out_tag = tag3_r;
  assign sq_dist = dist_r;
  assign busy    = tag1_r.valid | tag2_r.valid | tag3_r.valid;

endmodule

[design/closest_pair_brute_force.sv]
// top level: point store, pair sequencer and running minimum of the closest pair search
// loading accepts words while idle; busy stays low until the word with last_point
// the strobe follows once all pairs have left the distance unit; pairs issue one per cycle
// through the single read port of the point store, except while a row's first point is read
// fewer than two points: the result strobe is high in the cycle right after the last word
// rst_n is synchronous; the store is not cleared, count and flags are; results cannot stall
`timescale 1ns / 1ps

module closest_pair_brute_force (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [15:0]                  in_point_x,
  input  logic signed [15:0]                  in_point_y,
  input  logic                                in_last_point,
  output logic                                out_valid,
  output logic [cpbf_pkg::OUT_DIST_W-1:0]     out_min_sq_distance,
  output logic [cpbf_pkg::INDEX_W-1:0]        out_first_index,
  output logic [cpbf_pkg::INDEX_W-1:0]        out_second_index,
  output logic [cpbf_pkg::PAIR_W-1:0]         out_pair_count,
  output logic                                out_no_pair,
  output logic                                out_overflow
);
  import cpbf_pkg::*;

  cpbf_state_t state_r, state_nxt;

  logic [2*COORD_WIDTH-1:0] mem [MAX_POINTS];

  logic                   accept;
  logic                   room;
  logic [CNT_W-1:0]       count_r, count_after;
  logic                   dropped_r;
  logic [IDX_W-1:0]       i_r, j_r;
  logic [IDX_W-1:0]       last_idx, second_last_idx;
  logic                   issue_i, issue_j;
  logic [IDX_W-1:0]       raddr;
  logic                   rd_v_r, rd_is_j_r;
  logic [IDX_W-1:0]       rd_i_r, rd_j_r;
  logic [2*COORD_WIDTH-1:0] rd_data_r;
  logic [2*COORD_WIDTH-1:0] pi_r;
  cpbf_tag_t              dist_in_tag, dist_out_tag;
  logic [DIST_W-1:0]      pair_dist;
  logic                   dist_busy;
  logic                   have_r;
  logic [DIST_W-1:0]      best_r;
  logic [IDX_W-1:0]       best_i_r, best_j_r;
  logic [PAIR_W-1:0]      pairs_r;

  assign accept          = start && (state_r == S_IDLE);
  assign room            = count_r < CNT_W'(MAX_POINTS);
  assign count_after     = room ? count_r + CNT_W'(1) : count_r;
  assign last_idx        = IDX_W'(count_r - CNT_W'(1));
  assign second_last_idx = IDX_W'(count_r - CNT_W'(2));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_last_point) begin
          state_nxt = (count_after >= CNT_W'(2)) ? S_ISSUE_I : S_DONE;
        end
      end
      S_ISSUE_I: state_nxt = S_ISSUE_J;
      S_ISSUE_J: begin
        if (j_r == last_idx) begin
          state_nxt = (i_r == second_last_idx) ? S_DRAIN : S_ISSUE_I;
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !dist_busy && !dist_out_tag.valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy    = 1'b1;
    issue_i = 1'b0;
    issue_j = 1'b0;
    raddr   = j_r;
    unique case (state_r)
      S_IDLE:    busy = 1'b0;
      S_ISSUE_I: begin
        issue_i = 1'b1;
        raddr   = i_r;
      end
      S_ISSUE_J: issue_j = 1'b1;
      S_DRAIN:   busy = 1'b1;
      S_DONE:    busy = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count_r[IDX_W-1:0]] <= {in_point_x[COORD_WIDTH-1:0], in_point_y[COORD_WIDTH-1:0]};
    end
    if (issue_i || issue_j) begin
      rd_data_r <= mem[raddr];
    end
  end

  // load count, drop flag and pair indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (state_r == S_DONE) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (accept) begin
      count_r <= count_after;
      if (!room) begin
        dropped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_r <= '0;
    end else if (issue_i) begin
      j_r <= i_r + IDX_W'(1);
    end else if (issue_j) begin
      if (j_r == last_idx) begin
        i_r <= i_r + IDX_W'(1);
      end else begin
        j_r <= j_r + IDX_W'(1);
      end
    end
  end

  // read tag stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue_i || issue_j;
    end
  end

  always_ff @(posedge clk) begin
    rd_is_j_r <= issue_j;
    rd_i_r    <= i_r;
    rd_j_r    <= j_r;
    if (rd_v_r && !rd_is_j_r) begin
      pi_r <= rd_data_r;
    end
  end

  assign dist_in_tag.valid = rd_v_r && rd_is_j_r;
  assign dist_in_tag.i     = rd_i_r;
  assign dist_in_tag.j     = rd_j_r;

  cpbf_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (dist_in_tag),
    .ax      (pi_r[2*COORD_WIDTH-1:COORD_WIDTH]),
    .ay      (pi_r[COORD_WIDTH-1:0]),
    .bx      (rd_data_r[2*COORD_WIDTH-1:COORD_WIDTH]),
    .by      (rd_data_r[COORD_WIDTH-1:0]),
    .out_tag (dist_out_tag),
    .sq_dist (pair_dist),
    .busy    (dist_busy)
  );

  // running minimum, strictly smaller replaces
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      pairs_r <= '0;
    end else if (state_r == S_DONE) begin
      have_r  <= 1'b0;
      pairs_r <= '0;
    end else if (dist_out_tag.valid) begin
      pairs_r <= pairs_r + PAIR_W'(1);
      if (!have_r || pair_dist < best_r) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dist_out_tag.valid && (!have_r || pair_dist < best_r)) begin
      best_r   <= pair_dist;
      best_i_r <= dist_out_tag.i;
      best_j_r <= dist_out_tag.j;
    end
  end

  assign out_valid           = (state_r == S_DONE);
  assign out_min_sq_distance = have_r ? OUT_DIST_W'(best_r) : '0;
  assign out_first_index     = have_r ? INDEX_W'(best_i_r) : '0;
  assign out_second_index    = have_r ? INDEX_W'(best_j_r) : '0;
  assign out_pair_count      = pairs_r;
  assign out_no_pair         = !have_r;
  assign out_overflow        = dropped_r;

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe not followed by idle");

  a_no_result_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_point |=> !out_valid)
    else $error("result without last point");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_pair |-> out_second_index > out_first_index)
    else $error("pair indices out of order");

  a_pairs_match_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_no_pair == (out_pair_count == '0)))
    else $error("no_pair disagrees with pair count");
`endif

endmodule
